>>> sv/periodic_pattern_overlay_macros.svh
// ----------------------------------------------------------------------------
// Periodic pattern overlay assertion macros
// Shorthand for the clocked checks used in the overlay RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_PATTERN_OVERLAY_MACROS_SVH
`define PERIODIC_PATTERN_OVERLAY_MACROS_SVH

// same-cycle implication, held off during reset
`define PPO_ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define PPO_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/ppo_pkg.sv
// ----------------------------------------------------------------------------
// Periodic pattern overlay package
// Field widths, register and mode codes, and the words carried down the pipe.
// ----------------------------------------------------------------------------
package ppo_pkg;

  localparam int COORD_W = 12;
  localparam int FRAME_W = 20;
  localparam int SAMP_W  = 16;
  localparam int WL_W    = 12;
  localparam int OV_W    = 17;
  localparam int KIND_W  = 2;
  localparam int ORI_W   = 2;

  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int REG_W   = 3;

  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int ROOT_W  = (SQ_W + 1) / 2;
  localparam int DIST_W  = SQ_W;
  localparam int ZDIV_W  = 2 * WL_W - 2;
  localparam int WL4_W   = WL_W + 2;
  localparam int PH_A_W  = WL_W + 3;

  localparam logic [OV_W-1:0] ONE_Q16 = 17'h10000;

  localparam int DEF_MAX_DIM      = 4096;
  localparam int DEF_MAX_WAVE     = 2048;
  localparam int DEF_SAMPLE_BITS  = 16;
  localparam int DEF_SINE_ENTRIES = 1024;

  localparam logic [KIND_W-1:0] KIND_ZONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEP = 2'd2;

  localparam logic [ORI_W-1:0] ORI_CIRC  = 2'd0;
  localparam logic [ORI_W-1:0] ORI_VERT  = 2'd1;
  localparam logic [ORI_W-1:0] ORI_HORZ  = 2'd2;
  localparam logic [ORI_W-1:0] ORI_SLANT = 2'd3;

  localparam logic [REG_W-1:0] REG_KIND   = 3'd0;
  localparam logic [REG_W-1:0] REG_ORIENT = 3'd1;
  localparam logic [REG_W-1:0] REG_CX     = 3'd2;
  localparam logic [REG_W-1:0] REG_CY     = 3'd3;
  localparam logic [REG_W-1:0] REG_WAVE   = 3'd4;
  localparam logic [REG_W-1:0] REG_FROZEN = 3'd5;
  localparam logic [REG_W-1:0] REG_OV     = 3'd6;
  localparam logic [REG_W-1:0] REG_LUMA   = 3'd7;

  typedef struct packed {
    logic [SAMP_W-1:0] s0;
    logic [SAMP_W-1:0] s1;
    logic [SAMP_W-1:0] s2;
  } pix_t;

  typedef struct packed {
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [COORD_W-1:0] row;
    logic [FRAME_W-1:0] shift;
  } geo_t;

  typedef struct packed {
    logic [SQ_W-1:0] sq;
    geo_t            geo;
    pix_t            pix;
  } sq_tag_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    geo_t              geo;
    pix_t              pix;
  } root_tag_t;

  typedef struct packed {
    logic step_lo;
    pix_t pix;
  } step_tag_t;

endpackage

>>> sv/periodic_pattern_overlay.sv
// Pipeline at default parameters: 11 single stages, 13 root stages, two 25-stage
//   dividers and a log2(SINE_ENTRIES)+1 stage index divider.
// Throughput: one word per cycle; the pipe halts only while the output skid
//   register holds a word.
// Reset: rst (synchronous) empties the pipe and loads register defaults.
`include "periodic_pattern_overlay_macros.svh"

// ----------------------------------------------------------------------------
// Periodic pattern overlay
// Scales each pixel's samples (only sample zero when luma_only is set) by a zone, sine or step shading factor.
// ----------------------------------------------------------------------------
module periodic_pattern_overlay #(
  parameter int MAX_DIM      = ppo_pkg::DEF_MAX_DIM,
  parameter int MAX_WAVE     = ppo_pkg::DEF_MAX_WAVE,
  parameter int SAMPLE_BITS  = ppo_pkg::DEF_SAMPLE_BITS,
  parameter int SINE_ENTRIES = ppo_pkg::DEF_SINE_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppo_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppo_pkg::DATA_W-1:0]  pwdata,
  output logic [ppo_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ppo_pkg::COORD_W-1:0] row,
  input  logic [ppo_pkg::COORD_W-1:0] column,
  input  logic [ppo_pkg::FRAME_W-1:0] frame_number,
  input  logic [ppo_pkg::SAMP_W-1:0]  sample_zero,
  input  logic [ppo_pkg::SAMP_W-1:0]  sample_one,
  input  logic [ppo_pkg::SAMP_W-1:0]  sample_two,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ppo_pkg::SAMP_W-1:0]  out_zero,
  output logic [ppo_pkg::SAMP_W-1:0]  out_one,
  output logic [ppo_pkg::SAMP_W-1:0]  out_two
);
  import ppo_pkg::*;

  localparam int IDX_W  = $clog2(SINE_ENTRIES);
  localparam int QC_W   = IDX_W + 1;
  localparam int NUMC_W = PH_A_W + QC_W;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [SAMP_W-1:0] SMASK = SAMP_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

  // sin(a/N * pi/2) in Q1.15 by a fixed Q30 series
  function automatic logic [15:0] quarter_sine(input logic [63:0] a);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (a * HALF_PI_Q30 + 64'(SINE_ENTRIES / 2)) / SINE_ENTRIES;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = sum - term;
    sum  = (sum + 64'd16384) >> 15;
    if (sum > 64'd32767) begin
      sum = 64'd32767;
    end
    return sum[15:0];
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] a;
    logic [63:0] n;
    n = 64'(SINE_ENTRIES);
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      a = 64'(4 * k);
      if (a <= n) begin
        tab[k] = quarter_sine(a);
      end else if (a <= 2 * n) begin
        tab[k] = quarter_sine(2 * n - a);
      end else if (a <= 3 * n) begin
        tab[k] = -quarter_sine(a - 2 * n);
      end else begin
        tab[k] = -quarter_sine(4 * n - a);
      end
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine();

  function automatic logic [COORD_W-1:0] sat_dim(input logic [COORD_W-1:0] v);
    return (int'(v) > MAX_DIM - 1) ? COORD_W'(MAX_DIM - 1) : v;
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [KIND_W-1:0]  pattern_kind;
  logic [ORI_W-1:0]   orientation;
  logic [COORD_W-1:0] center_x;
  logic [COORD_W-1:0] center_y;
  logic [WL_W-1:0]    wavelength;
  logic               frozen;
  logic [OV_W-1:0]    overlay_strength;
  logic               luma_only;
  logic               wr;
  logic [REG_W-1:0]   reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_kind     <= KIND_SINE;
      orientation      <= ORI_CIRC;
      center_x         <= '0;
      center_y         <= '0;
      wavelength       <= WL_W'(16);
      frozen           <= 1'b1;
      overlay_strength <= OV_W'(6554);
      luma_only        <= 1'b0;
    end else if (wr) begin
      unique case (reg_sel)
        REG_KIND:   pattern_kind     <= pwdata[KIND_W-1:0];
        REG_ORIENT: orientation      <= pwdata[ORI_W-1:0];
        REG_CX:     center_x         <= pwdata[COORD_W-1:0];
        REG_CY:     center_y         <= pwdata[COORD_W-1:0];
        REG_WAVE:   wavelength       <= pwdata[WL_W-1:0];
        REG_FROZEN: frozen           <= pwdata[0];
        REG_OV:     overlay_strength <= pwdata[OV_W-1:0];
        REG_LUMA:   luma_only        <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KIND:   prdata = DATA_W'(pattern_kind);
      REG_ORIENT: prdata = DATA_W'(orientation);
      REG_CX:     prdata = DATA_W'(center_x);
      REG_CY:     prdata = DATA_W'(center_y);
      REG_WAVE:   prdata = DATA_W'(wavelength);
      REG_FROZEN: prdata = DATA_W'(frozen);
      REG_OV:     prdata = DATA_W'(overlay_strength);
      REG_LUMA:   prdata = DATA_W'(luma_only);
      default:    prdata = '0;
    endcase
  end

  // derived settings, refreshed every cycle
  logic [WL_W-1:0]   wl_clamp;
  logic [OV_W-1:0]   ov_clamp;
  logic [WL_W-1:0]   cfg_wl;
  logic [WL_W-1:0]   cfg_half;
  logic [WL4_W-1:0]  cfg_wl4;
  logic [ZDIV_W-1:0] cfg_zdiv;
  logic [OV_W-1:0]   cfg_ov;

  always_comb begin
    wl_clamp = wavelength;
    if (wavelength < WL_W'(4)) begin
      wl_clamp = WL_W'(4);
    end else if (int'(wavelength) > MAX_WAVE) begin
      wl_clamp = WL_W'(MAX_WAVE);
    end
    ov_clamp = (overlay_strength > ONE_Q16) ? ONE_Q16 : overlay_strength;
  end

  always_ff @(posedge clk) begin
    cfg_wl   <= wl_clamp;
    cfg_half <= wl_clamp >> 1;
    cfg_wl4  <= {wl_clamp, 2'b00};
    cfg_zdiv <= ZDIV_W'(((2 * WL_W)'(wl_clamp) * (2 * WL_W)'(wl_clamp)) >> 2);
    cfg_ov   <= ov_clamp;
  end

  // --------------------------------------------------------------------------
  // output register and skid; the pipe advances while the skid is empty
  // --------------------------------------------------------------------------
  logic adv;
  logic skid_valid;
  pix_t skid_data;
  pix_t out_data;
  logic vj;
  pix_t res_j;

  assign adv      = !skid_valid;
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // stages 1-3: offsets, squares, squared distance
  // --------------------------------------------------------------------------
  logic               v1, v2, v3;
  geo_t               g1, g2, g3;
  pix_t               p1, p2, p3;
  logic [COORD_W-1:0] row_s, col_s, cx_s, cy_s;
  logic [2*COORD_W-1:0] dx2, dy2;
  logic [SQ_W-1:0]    sq3;
  logic               use_x, use_y;

  assign row_s = sat_dim(row);
  assign col_s = sat_dim(column);
  assign cx_s  = sat_dim(center_x);
  assign cy_s  = sat_dim(center_y);
  assign use_x = orientation != ORI_HORZ;
  assign use_y = (orientation == ORI_CIRC) || (orientation == ORI_HORZ);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1.dx    <= (col_s > cx_s) ? col_s - cx_s : cx_s - col_s;
      g1.dy    <= (row_s > cy_s) ? row_s - cy_s : cy_s - row_s;
      g1.row   <= row_s;
      g1.shift <= frozen ? '0 : frame_number;
      p1.s0    <= sample_zero & SMASK;
      p1.s1    <= sample_one & SMASK;
      p1.s2    <= sample_two & SMASK;
      dx2      <= (2 * COORD_W)'(g1.dx) * (2 * COORD_W)'(g1.dx);
      dy2      <= (2 * COORD_W)'(g1.dy) * (2 * COORD_W)'(g1.dy);
      g2       <= g1;
      p2       <= p1;
      sq3      <= (use_x ? SQ_W'(dx2) : '0) + (use_y ? SQ_W'(dy2) : '0);
      g3       <= g2;
      p3       <= p2;
    end
  end

  // --------------------------------------------------------------------------
  // root, then zone quotient
  // --------------------------------------------------------------------------
  sq_tag_t           tag3, tag_rt;
  logic              v_rt;
  logic [ROOT_W-1:0] root_rt;
  root_tag_t         tag_za_in, tag_za;
  logic              v_za;
  logic [SQ_W-1:0]   quo_za;

  assign tag3 = '{sq: sq3, geo: g3, pix: p3};

  ppo_isqrt #(
    .IN_W  (SQ_W + 1),
    .TAG_W ($bits(sq_tag_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v3),
    .value     ({1'b0, sq3}),
    .tag_in    (tag3),
    .out_valid (v_rt),
    .root      (root_rt),
    .tag_out   (tag_rt)
  );

  assign tag_za_in = '{root: root_rt, geo: tag_rt.geo, pix: tag_rt.pix};

  ppo_div #(
    .NUM_W (SQ_W),
    .DEN_W (ZDIV_W),
    .STEPS (SQ_W),
    .TAG_W ($bits(root_tag_t))
  ) u_zone_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v_rt),
    .num       (tag_rt.sq),
    .den       (cfg_zdiv),
    .tag_in    (tag_za_in),
    .out_valid (v_za),
    .quo       (quo_za),
    .rem       (),
    .tag_out   (tag_za)
  );

  // --------------------------------------------------------------------------
  // distance, then phase
  // --------------------------------------------------------------------------
  logic              vd;
  logic [DIST_W-1:0] dist_d;
  logic [DIST_W-1:0] base;
  pix_t              p_d;
  logic              v_ph;
  logic [WL_W-1:0]   phase;
  pix_t              p_ph;

  always_comb begin
    if (pattern_kind == KIND_ZONE) begin
      base = quo_za;
    end else if (orientation == ORI_CIRC) begin
      base = DIST_W'(tag_za.root);
    end else if (orientation == ORI_HORZ) begin
      base = DIST_W'(tag_za.geo.dy);
    end else begin
      base = DIST_W'(tag_za.geo.dx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (adv) begin
      vd <= v_za;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_d <= base + (orientation == ORI_SLANT ? DIST_W'(tag_za.geo.row) : '0)
              + DIST_W'(tag_za.geo.shift);
      p_d    <= tag_za.pix;
    end
  end

  ppo_div #(
    .NUM_W (DIST_W),
    .DEN_W (WL_W),
    .STEPS (DIST_W),
    .TAG_W ($bits(pix_t))
  ) u_phase_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vd),
    .num       (dist_d),
    .den       (cfg_wl),
    .tag_in    (p_d),
    .out_valid (v_ph),
    .quo       (),
    .rem       (phase),
    .tag_out   (p_ph)
  );

  // --------------------------------------------------------------------------
  // sine table index
  // --------------------------------------------------------------------------
  logic              ve;
  logic [NUMC_W-1:0] numc_e;
  step_tag_t         st_e;
  logic [PH_A_W-1:0] ph_a;
  logic              v_ix;
  logic [QC_W-1:0]   quo_ix;
  step_tag_t         st_ix;

  assign ph_a = PH_A_W'({phase, 2'b00})
              + (pattern_kind == KIND_ZONE ? PH_A_W'(cfg_wl) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (adv) begin
      ve <= v_ph;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      numc_e <= NUMC_W'(ph_a) * NUMC_W'(SINE_ENTRIES);
      st_e   <= '{step_lo: phase < cfg_half, pix: p_ph};
    end
  end

  ppo_div #(
    .NUM_W (NUMC_W),
    .DEN_W (WL4_W),
    .STEPS (QC_W),
    .TAG_W ($bits(step_tag_t))
  ) u_index_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (ve),
    .num       (numc_e),
    .den       (cfg_wl4),
    .tag_in    (st_e),
    .out_valid (v_ix),
    .quo       (quo_ix),
    .rem       (),
    .tag_out   (st_ix)
  );

  // --------------------------------------------------------------------------
  // table read, drop, factor, scaling
  // --------------------------------------------------------------------------
  logic               vf, vg, vh, vi;
  logic [IDX_W-1:0]   idx_f;
  step_tag_t          st_f, st_g, st_h;
  logic signed [15:0] rom_g;
  logic [15:0]        w_g;
  logic [15:0]        drop_h;
  logic [OV_W-1:0]    factor_i;
  pix_t               p_i;
  logic [32:0]        prod0, prod1, prod2;

  assign w_g   = {~rom_g[15], rom_g[14:0]};
  assign prod0 = 33'(p_i.s0) * 33'(factor_i);
  assign prod1 = 33'(p_i.s1) * 33'(factor_i);
  assign prod2 = 33'(p_i.s2) * 33'(factor_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
      vg <= 1'b0;
      vh <= 1'b0;
      vi <= 1'b0;
      vj <= 1'b0;
    end else if (adv) begin
      vf <= v_ix;
      vg <= vf;
      vh <= vg;
      vi <= vh;
      vj <= vi;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // wrap the index back into the table
      idx_f <= (int'(quo_ix) >= SINE_ENTRIES) ? IDX_W'(quo_ix - QC_W'(SINE_ENTRIES))
                                               : IDX_W'(quo_ix);
      st_f  <= st_ix;
      rom_g <= SINE_ROM[idx_f];
      st_g  <= st_f;
      drop_h <= 16'((33'(w_g) * 33'(cfg_ov) + 33'd32768) >> 16);
      st_h  <= st_g;
      if (pattern_kind == KIND_STEP) begin
        factor_i <= st_h.step_lo ? ONE_Q16 - cfg_ov : ONE_Q16;
      end else begin
        factor_i <= ONE_Q16 - OV_W'(drop_h);
      end
      p_i      <= st_h.pix;
      res_j.s0 <= prod0[31:16];
      res_j.s1 <= luma_only ? p_i.s1 : prod1[31:16];
      res_j.s2 <= luma_only ? p_i.s2 : prod2[31:16];
    end
  end

  // --------------------------------------------------------------------------
  // output side
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= vj;
      end
    end else if (!out_valid) begin
      out_valid <= vj;
    end else if (vj) begin
      // hold the finished word while the consumer stalls
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      out_data <= skid_valid ? skid_data : res_j;
    end else if (!out_valid) begin
      out_data <= res_j;
    end else if (adv) begin
      skid_data <= res_j;
    end
  end

  assign out_zero = out_data.s0;
  assign out_one  = out_data.s1;
  assign out_two  = out_data.s2;

  `PPO_ASSERT_SAME(a_skid_needs_out, clk, rst, skid_valid, out_valid, "skid word without output word")
  `PPO_ASSERT_NEXT(a_stall_keeps_word, clk, rst, out_valid && !out_ready && !skid_valid && vj, skid_valid, "finished word dropped at stalled output")
  `PPO_ASSERT_SAME(a_index_range, clk, rst, vf, int'(idx_f) < SINE_ENTRIES, "sine index past table end")
  `PPO_ASSERT_SAME(a_factor_range, clk, rst, vi, factor_i <= ONE_Q16, "shading factor above one")

endmodule

>>> sv/ppo_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the divisor is a static input. The top
// (NUM_W - STEPS) numerator bits must already be below the divisor.
// ----------------------------------------------------------------------------
module ppo_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 12,
  parameter int STEPS = 25,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [STEPS-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic [TAG_W-1:0] tag_out
);

  logic             vq [STEPS];
  logic [DEN_W-1:0] rq [STEPS];
  logic [STEPS-1:0] qq [STEPS];
  logic [NUM_W-1:0] nq [STEPS];
  logic [TAG_W-1:0] tq [STEPS];

  logic [DEN_W-1:0] rem0;

  assign rem0 = DEN_W'(num >> STEPS);

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic             v_prev;
    logic [DEN_W-1:0] r_prev;
    logic [STEPS-1:0] q_prev;
    logic [NUM_W-1:0] n_prev;
    logic [TAG_W-1:0] t_prev;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign v_prev = in_valid;
      assign r_prev = rem0;
      assign q_prev = '0;
      assign n_prev = num;
      assign t_prev = tag_in;
    end else begin : g_next
      assign v_prev = vq[i-1];
      assign r_prev = rq[i-1];
      assign q_prev = qq[i-1];
      assign n_prev = nq[i-1];
      assign t_prev = tq[i-1];
    end

    // bring down the next numerator bit
    assign trial = {r_prev, n_prev[STEPS-1-i]};
    assign ge    = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[i] <= 1'b0;
      end else if (en) begin
        vq[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rq[i] <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        qq[i] <= (q_prev << 1) | STEPS'(ge);
        nq[i] <= n_prev;
        tq[i] <= t_prev;
      end
    end
  end

  assign out_valid = vq[STEPS-1];
  assign quo       = qq[STEPS-1];
  assign rem       = rq[STEPS-1];
  assign tag_out   = tq[STEPS-1];

endmodule

>>> sv/ppo_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, two radicand bits per stage.
// ----------------------------------------------------------------------------
module ppo_isqrt #(
  parameter int IN_W  = 26,
  parameter int TAG_W = 8,
  localparam int ROOT_W = IN_W / 2,
  localparam int REM_W  = ROOT_W + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   value,
  input  logic [TAG_W-1:0]  tag_in,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root,
  output logic [TAG_W-1:0]  tag_out
);

  logic              vq [ROOT_W];
  logic [REM_W-1:0]  rq [ROOT_W];
  logic [ROOT_W-1:0] oq [ROOT_W];
  logic [IN_W-1:0]   xq [ROOT_W];
  logic [TAG_W-1:0]  tq [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic              v_prev;
    logic [REM_W-1:0]  r_prev;
    logic [ROOT_W-1:0] o_prev;
    logic [IN_W-1:0]   x_prev;
    logic [TAG_W-1:0]  t_prev;
    logic [REM_W-1:0]  rem_t;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_prev = in_valid;
      assign r_prev = '0;
      assign o_prev = '0;
      assign x_prev = value;
      assign t_prev = tag_in;
    end else begin : g_next
      assign v_prev = vq[i-1];
      assign r_prev = rq[i-1];
      assign o_prev = oq[i-1];
      assign x_prev = xq[i-1];
      assign t_prev = tq[i-1];
    end

    assign rem_t = {r_prev[REM_W-3:0], x_prev[IN_W-1-2*i -: 2]};
    assign trial = {o_prev, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[i] <= 1'b0;
      end else if (en) begin
        vq[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rq[i] <= ge ? rem_t - trial : rem_t;
        oq[i] <= (o_prev << 1) | ROOT_W'(ge);
        xq[i] <= x_prev;
        tq[i] <= t_prev;
      end
    end
  end

  assign out_valid = vq[ROOT_W-1];
  assign root      = oq[ROOT_W-1];
  assign tag_out   = tq[ROOT_W-1];

endmodule
